// File: rtl/core/cbm_pkg.sv
// Shared types, codes and helpers for the cartridge bank mapper with IRQ counter
package cbm_pkg;

	localparam int CHR_SLOTS = 8;
	localparam int CHR_IDX_W = $clog2(CHR_SLOTS);
	localparam int PRG_SLOTS = 3;
	localparam int PRG_IDX_W = 2;

	// item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// write regions, address bits 15..12
	localparam logic [3:0] RGN_RELOAD0 = 4'h8;
	localparam logic [3:0] RGN_RELOAD1 = 4'h9;
	localparam logic [3:0] RGN_RELOAD2 = 4'hA;
	localparam logic [3:0] RGN_RELOAD3 = 4'hB;
	localparam logic [3:0] RGN_ENABLE  = 4'hC;
	localparam logic [3:0] RGN_ACK     = 4'hD;
	localparam logic [3:0] RGN_SELECT  = 4'hE;
	localparam logic [3:0] RGN_BANK    = 4'hF;

	// sub-decode of the bank region, address bits 11..10
	localparam logic [1:0] SUB_PRG_HI = 2'b00;
	localparam logic [1:0] SUB_MIRROR = 2'b10;
	localparam logic [1:0] SUB_CHR    = 2'b11;

	// selected register codes
	localparam logic [3:0] SEL_PRG0 = 4'd1;
	localparam logic [3:0] SEL_PRG2 = 4'd3;
	localparam logic [3:0] SEL_RAM  = 4'd4;

	// fixed program window
	localparam logic [PRG_IDX_W-1:0] PRG_FIXED_WIN = 2'd3;

	localparam logic [15:0] TICK_TOP = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_PRG_LIMIT = 1'b0;
	localparam logic CFG_CHR_LIMIT = 1'b1;

	localparam logic [7:0] PRG_LIMIT_RST = 8'd31;
	localparam logic [7:0] CHR_LIMIT_RST = 8'd255;

	typedef struct packed {
		logic [1:0]           mode;
		logic [15:0]          address;
		logic [7:0]           data;
		logic [CHR_IDX_W-1:0] chr_slot;
	} item_t;

	typedef struct packed {
		logic       irq_line;
		logic       mirror_vertical;
		logic [7:0] prg_bank;
		logic [7:0] ram_bank;
		logic [7:0] chr_bank;
	} result_t;

	// configuration write group
	typedef struct packed {
		logic       we;
		logic       index;
		logic [7:0] data;
	} cfg_wr_t;

	// bank values above the limit are masked with it
	function automatic logic [7:0] clamp_bank(input logic [7:0] v, input logic [7:0] lim);
		return (v > lim) ? (v & lim) : v;
	endfunction

endpackage

// File: rtl/core/cbm_core.sv
// Mapper state, next-state decode and per-word result computation
module cbm_core import cbm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_wr_t cfg,
	output result_t result
);

	logic [7:0]  prg_limit_q, chr_limit_q;
	logic [15:0] reload_q, tick_q;
	logic        enabled_q, irq_delay_q, irq_flag_q, mirror_q;
	logic [7:0]  select_q, ram_bank_q;
	logic [7:0]  prg_q [PRG_SLOTS];
	logic [7:0]  chr_q [CHR_SLOTS];

	logic [15:0] reload_n, tick_n, tick_inc;
	logic        enabled_n, irq_delay_n, irq_flag_n, mirror_n;
	logic [7:0]  select_n, ram_bank_n;
	logic [7:0]  prg_n [PRG_SLOTS];
	logic [7:0]  chr_n [CHR_SLOTS];
	logic [3:0]  sel;
	logic [PRG_IDX_W-1:0] sel_idx, hi_idx, win;
	logic [7:0]  pb, cb;

	assign sel      = select_q[3:0];
	assign sel_idx  = PRG_IDX_W'(sel - SEL_PRG0);
	assign hi_idx   = item.address[PRG_IDX_W-1:0];
	assign win      = item.address[14:13];
	assign tick_inc = tick_q + 16'd1;

	// next state for the current word
	always_comb begin
		reload_n    = reload_q;
		tick_n      = tick_q;
		enabled_n   = enabled_q;
		irq_delay_n = irq_delay_q;
		irq_flag_n  = irq_flag_q;
		mirror_n    = mirror_q;
		select_n    = select_q;
		ram_bank_n  = ram_bank_q;
		prg_n       = prg_q;
		chr_n       = chr_q;
		case (item.mode)
			MODE_WRITE: begin
				unique case (item.address[15:12])
					RGN_RELOAD0: reload_n[3:0]   = item.data[3:0];
					RGN_RELOAD1: reload_n[7:4]   = item.data[3:0];
					RGN_RELOAD2: reload_n[11:8]  = item.data[3:0];
					RGN_RELOAD3: reload_n[15:12] = item.data[3:0];
					RGN_ENABLE: begin
						enabled_n  = (item.data[3:0] != 4'd0);
						if (enabled_n) begin
							tick_n = reload_q;
						end
						irq_flag_n = 1'b0;
					end
					RGN_ACK: irq_flag_n = 1'b0;
					RGN_SELECT: select_n = item.data;
					RGN_BANK: begin
						// selected register first
						if (sel >= SEL_PRG0 && sel <= SEL_PRG2) begin
							prg_n[sel_idx] = clamp_bank({3'b0, prg_q[sel_idx][4], item.data[3:0]},
								prg_limit_q);
						end else if (sel == SEL_RAM) begin
							ram_bank_n = clamp_bank(item.data, prg_limit_q);
						end
						// then the address-decoded target
						case (item.address[11:10])
							SUB_PRG_HI: begin
								if (hi_idx != PRG_FIXED_WIN) begin
									prg_n[hi_idx] = clamp_bank({3'b0, item.data[4], prg_n[hi_idx][3:0]},
										prg_limit_q);
								end
							end
							SUB_MIRROR: mirror_n = item.data[0];
							SUB_CHR: chr_n[item.address[CHR_IDX_W-1:0]] =
								clamp_bank(item.data, chr_limit_q);
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			MODE_TICK: begin
				if (irq_delay_q) begin
					irq_delay_n = 1'b0;
					irq_flag_n  = 1'b1;
				end
				if (enabled_q) begin
					if (tick_inc == TICK_TOP) begin
						tick_n      = reload_q;
						irq_delay_n = 1'b1;
					end else begin
						tick_n = tick_inc;
					end
				end
			end
			default: ;
		endcase
	end

	// query lookups read the current state
	always_comb begin
		pb = 8'd0;
		cb = 8'd0;
		if (item.mode == MODE_QUERY) begin
			if (item.address[15]) begin
				pb = (win == PRG_FIXED_WIN) ? prg_limit_q : prg_q[win];
			end
			cb = chr_q[item.chr_slot];
		end
	end

	assign result.irq_line        = irq_flag_n;
	assign result.mirror_vertical = mirror_n;
	assign result.prg_bank        = pb;
	assign result.ram_bank        = ram_bank_n;
	assign result.chr_bank        = cb;

	// state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_limit_q <= PRG_LIMIT_RST;
			chr_limit_q <= CHR_LIMIT_RST;
			reload_q    <= '0;
			tick_q      <= '0;
			enabled_q   <= 1'b0;
			irq_delay_q <= 1'b0;
			irq_flag_q  <= 1'b0;
			mirror_q    <= 1'b0;
			select_q    <= '0;
			ram_bank_q  <= '0;
			for (int i = 0; i < PRG_SLOTS; i++) begin
				prg_q[i] <= 8'(i);
			end
			for (int i = 0; i < CHR_SLOTS; i++) begin
				chr_q[i] <= 8'(i);
			end
		end else begin
			if (cfg.we) begin
				if (cfg.index == CFG_PRG_LIMIT) begin
					prg_limit_q <= cfg.data;
				end else begin
					chr_limit_q <= cfg.data;
				end
			end
			if (step) begin
				reload_q    <= reload_n;
				tick_q      <= tick_n;
				enabled_q   <= enabled_n;
				irq_delay_q <= irq_delay_n;
				irq_flag_q  <= irq_flag_n;
				mirror_q    <= mirror_n;
				select_q    <= select_n;
				ram_bank_q  <= ram_bank_n;
				prg_q       <= prg_n;
				chr_q       <= chr_n;
			end
		end
	end

	// a freshly armed IRQ delay comes with the counter reloaded
	a_delay_reload: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_delay_q) |-> tick_q == reload_q)
		else $error("irq delay armed without counter reload");

	// a pending delay raises the flag on the next tick (it may re-arm on a wrap)
	a_delay_fires: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == MODE_TICK && irq_delay_q |=> irq_flag_q)
		else $error("pending irq delay did not raise the flag");

	// a stopped counter holds on ticks
	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == MODE_TICK && !enabled_q |=> $stable(tick_q))
		else $error("stopped counter moved");

endmodule

// File: rtl/core/cartridge_bank_mapper_irq_counter.sv
// Top level: input register, mapper core and result register with valid/stall handshake
// An accepted word waits in the input register; its result word is then captured in the result register.
// Throughput: one word per cycle while out_stall is low; the input register and the result register
// each hold one word, so a waiting result still lets one more word in before the input stalls.
// Reset (arst_n low, asynchronous): pipeline empty, mapper state cleared,
// banks back to slot i = bank i, limits back to 31 and 255.
module cartridge_bank_mapper_irq_counter import cbm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  item_t   in_word,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_word,
	input  logic    cfg_we,
	input  logic    cfg_index,
	input  logic [7:0] cfg_data
);

	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	result_t out_word_q;
	result_t core_result;
	logic    advance;
	cfg_wr_t cfg;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	cbm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_word;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_word_q <= core_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// a stall to the input side only comes from a held word in stage 1
	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with nothing held");

	// a word leaving stage 1 lands in the result register
	a_s1_lands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q)
		else $error("stage 1 word lost");

	// a drained result with nothing behind it empties the output
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !valid_s1 |=> !out_valid_q)
		else $error("result word repeated");

endmodule

// File: sim/cartridge_bank_mapper_irq_counter_test.sv
// Testbench for the cartridge bank mapper: table-driven and random words checked against a predictor
module cartridge_bank_mapper_irq_counter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cbm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int N_DIRECTED = 28;
	localparam int N_PHASES = 6;
	localparam int WORDS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 80;
	localparam result_t NO_RESULT = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	item_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	result_t out_word;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	cartridge_bank_mapper_irq_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor copy of the mapper state and limits
	logic [7:0]  prg_limit, chr_limit;
	logic [15:0] reload_val, timer;
	logic        timer_on, irq_pending, irq_q, mirror_q;
	logic [7:0]  sel_q, ram_win;
	logic [7:0]  prg_win [PRG_SLOTS];
	logic [7:0]  chr_win [CHR_SLOTS];

	result_t results_due [$];
	int mismatches = 0;
	int words_sent = 0;
	int results_checked = 0;
	int irq_results = 0;
	int send_pct = 0;
	int recv_pct = 0;
	bit pressure_armed = 1'b0;
	bit pressure_done = 1'b0;
	int hold_left = 0;

	function automatic logic [7:0] mask_to_limit(input logic [7:0] v, input logic [7:0] lim);
		if (v > lim)
			return v & lim;
		return v;
	endfunction

	function automatic void clear_mapper();
		prg_limit = PRG_LIMIT_RST;
		chr_limit = CHR_LIMIT_RST;
		reload_val = '0;
		timer = '0;
		timer_on = 1'b0;
		irq_pending = 1'b0;
		irq_q = 1'b0;
		mirror_q = 1'b0;
		sel_q = '0;
		ram_win = '0;
		for (int i = 0; i < PRG_SLOTS; i++)
			prg_win[i] = 8'(i);
		for (int i = 0; i < CHR_SLOTS; i++)
			chr_win[i] = 8'(i);
	endfunction

	// apply one word to the predictor, return the result word it yields
	function automatic result_t apply_word(input item_t w);
		result_t r;
		logic [3:0] reg_sel;
		int s;
		r = '0;
		case (w.mode)
			MODE_WRITE: begin
				case (w.address[15:12])
					RGN_RELOAD0: reload_val[3:0] = w.data[3:0];
					RGN_RELOAD1: reload_val[7:4] = w.data[3:0];
					RGN_RELOAD2: reload_val[11:8] = w.data[3:0];
					RGN_RELOAD3: reload_val[15:12] = w.data[3:0];
					RGN_ENABLE: begin
						timer_on = (w.data[3:0] != 4'd0);
						if (timer_on)
							timer = reload_val;
						irq_q = 1'b0;
					end
					RGN_ACK: irq_q = 1'b0;
					RGN_SELECT: sel_q = w.data;
					RGN_BANK: begin
						// selected register first, then the address sub-decode
						reg_sel = sel_q[3:0];
						if (reg_sel >= SEL_PRG0 && reg_sel <= SEL_PRG2) begin
							s = int'(reg_sel - SEL_PRG0);
							prg_win[s] = mask_to_limit({3'b000, prg_win[s][4], w.data[3:0]},
								prg_limit);
						end else if (reg_sel == SEL_RAM) begin
							ram_win = mask_to_limit(w.data, prg_limit);
						end
						case (w.address[11:10])
							SUB_PRG_HI: begin
								s = int'(w.address[1:0]);
								if (s < PRG_SLOTS)
									prg_win[s] = mask_to_limit({3'b000, w.data[4], prg_win[s][3:0]},
										prg_limit);
							end
							SUB_MIRROR: mirror_q = w.data[0];
							SUB_CHR: chr_win[w.address[CHR_IDX_W-1:0]] = mask_to_limit(w.data, chr_limit);
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			MODE_TICK: begin
				// delayed IRQ rises one tick after the wrap
				if (irq_pending) begin
					irq_pending = 1'b0;
					irq_q = 1'b1;
				end
				if (timer_on) begin
					timer = timer + 16'd1;
					if (timer == TICK_TOP) begin
						timer = reload_val;
						irq_pending = 1'b1;
					end
				end
			end
			MODE_QUERY: begin
				if (w.address[15]) begin
					if (w.address[14:13] == PRG_FIXED_WIN)
						r.prg_bank = prg_limit;
					else
						r.prg_bank = prg_win[w.address[14:13]];
				end
				r.chr_bank = chr_win[w.chr_slot];
			end
			default: ;
		endcase
		r.irq_line = irq_q;
		r.mirror_vertical = mirror_q;
		r.ram_bank = ram_win;
		return r;
	endfunction

	// random word, biased toward sequences that make the timer wrap and the banks move
	function automatic item_t random_word();
		item_t w;
		int pick;
		w.mode = MODE_WRITE;
		w.address = 16'($urandom);
		w.data = 8'($urandom);
		w.chr_slot = 3'($urandom);
		pick = $urandom_range(99);
		if (pick < 35) begin
			w.mode = MODE_TICK;
		end else if (pick < 55) begin
			w.mode = MODE_QUERY;
		end else if (pick < 65) begin
			// keep the upper reload nibbles high so wraps come within a few ticks
			w.address[15:12] = 4'($urandom_range(RGN_RELOAD0, RGN_RELOAD3));
			if (w.address[15:12] != RGN_RELOAD0 && $urandom_range(99) < 85)
				w.data[3:0] = 4'hF;
		end else if (pick < 71) begin
			w.address[15:12] = RGN_ENABLE;
			if (w.data[3:0] == 4'd0 && $urandom_range(99) < 80)
				w.data[0] = 1'b1;
		end else if (pick < 76) begin
			w.address[15:12] = RGN_ACK;
		end else if (pick < 85) begin
			w.address[15:12] = RGN_SELECT;
			if ($urandom_range(99) < 80)
				w.data[3:0] = 4'($urandom_range(0, 5));
		end else if (pick < 97) begin
			w.address[15:12] = RGN_BANK;
		end else begin
			// noise: any mode, any address
			w.mode = 2'($urandom);
		end
		return w;
	endfunction

	// offer one word, wait for the handshake, then queue its expected result
	task automatic send_word(input item_t w, input bit typed, input result_t want);
		result_t predicted;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_word(w);
		results_due.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_limits(input logic [7:0] prg, input logic [7:0] chr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_LIMIT;
		cfg_data <= prg;
		@(posedge clk);
		cfg_index <= CFG_CHR_LIMIT;
		cfg_data <= chr;
		@(posedge clk);
		cfg_we <= 1'b0;
		prg_limit = prg;
		chr_limit = chr;
	endtask

	// result side: check accepted words, drive random stalls and the long hold-off
	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			results_checked++;
			if (out_word.irq_line)
				irq_results++;
			if (results_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result word with nothing expected: %p", $time, out_word);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (out_word.irq_line !== want.irq_line
						|| out_word.mirror_vertical !== want.mirror_vertical
						|| out_word.prg_bank !== want.prg_bank
						|| out_word.ram_bank !== want.ram_bank
						|| out_word.chr_bank !== want.chr_bank) begin
					if (mismatches < 10)
						$display("%0t: mismatch irq/mir/prg/ram/chr got %0b %0b %0d %0d %0d want %0b %0b %0d %0d %0d",
							$time, out_word.irq_line, out_word.mirror_vertical,
							out_word.prg_bank, out_word.ram_bank, out_word.chr_bank,
							want.irq_line, want.mirror_vertical,
							want.prg_bank, want.ram_bank, want.chr_bank);
					mismatches++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (pressure_armed && !pressure_done) begin
			hold_left = HOLD_CYCLES;
			pressure_done = 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	// directed words; typed expectations only where the answer is obvious
	typedef struct {
		item_t   word;
		bit      typed;
		result_t want;
	} step_row_t;

	step_row_t directed_steps [N_DIRECTED] = '{
		// mapping right after reset
		'{'{MODE_QUERY, 16'h8000, 8'h00, 3'd0}, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0}},
		'{'{MODE_QUERY, 16'hA000, 8'h00, 3'd7}, 1'b1, '{1'b0, 1'b0, 8'd1, 8'd0, 8'd7}},
		'{'{MODE_QUERY, 16'hC000, 8'h00, 3'd2}, 1'b1, '{1'b0, 1'b0, 8'd2, 8'd0, 8'd2}},
		// fixed last window reads the limit
		'{'{MODE_QUERY, 16'hFFFF, 8'h00, 3'd5}, 1'b1, '{1'b0, 1'b0, 8'd31, 8'd0, 8'd5}},
		// query below the program area
		'{'{MODE_QUERY, 16'h7FFF, 8'h00, 3'd3}, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd0, 8'd3}},
		// unused mode, write below 0x8000, tick while stopped
		'{'{MODE_UNUSED, 16'hFFFF, 8'hFF, 3'd7}, 1'b1, NO_RESULT},
		'{'{MODE_WRITE, 16'h7FFF, 8'hFF, 3'd0}, 1'b1, NO_RESULT},
		'{'{MODE_TICK, 16'h0000, 8'h00, 3'd0}, 1'b1, NO_RESULT},
		// reload 0xFFFE, start, wrap, IRQ a tick later, ack, stop
		'{'{MODE_WRITE, 16'h8000, 8'hFE, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'h9FFF, 8'hFF, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hA000, 8'h0F, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hB123, 8'hFF, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hC000, 8'h01, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_TICK, 16'h0000, 8'h00, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_TICK, 16'hFFFF, 8'hFF, 3'd7}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hD000, 8'h00, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_TICK, 16'h0000, 8'h00, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hC000, 8'hF0, 3'd0}, 1'b0, NO_RESULT},
		// bank writes: program low nibble plus high bit, RAM window with clamp, mirroring
		'{'{MODE_WRITE, 16'hE000, 8'h01, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hF000, 8'hFF, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hE000, 8'hF4, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hF803, 8'hFF, 3'd0}, 1'b0, NO_RESULT},
		// unused select, character bank, dead sub-decodes
		'{'{MODE_WRITE, 16'hE000, 8'h05, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hFC07, 8'hFF, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hF403, 8'hAA, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_WRITE, 16'hF003, 8'hFF, 3'd0}, 1'b0, NO_RESULT},
		'{'{MODE_QUERY, 16'hE000, 8'h00, 3'd7}, 1'b0, NO_RESULT},
		'{'{MODE_QUERY, 16'h8000, 8'h00, 3'd0}, 1'b0, NO_RESULT}
	};

	logic [7:0] phase_prg [N_PHASES] = '{8'd31, 8'd0, 8'd255, 8'd15, 8'd0, 8'd255};
	logic [7:0] phase_chr [N_PHASES] = '{8'd255, 8'd0, 8'd255, 8'd63, 8'd0, 8'd0};

	// stimulus: reset, directed table, then random phases under several limit settings
	initial begin
		logic [7:0] prg, chr;
		clear_mapper();
		send_pct = 37;
		recv_pct = 59;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_steps[i].word, directed_steps[i].typed, directed_steps[i].want);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			prg = phase_prg[p];
			chr = phase_chr[p];
			if (p == 4) begin
				prg = 8'($urandom);
				chr = 8'($urandom);
			end
			program_limits(prg, chr);
			// idling: receiver-heavy stalls, then swapped, then none
			if (p < 2) begin
				send_pct = 37;
				recv_pct = 59;
			end else if (p < 4) begin
				send_pct = 59;
				recv_pct = 37;
			end else begin
				send_pct = 0;
				recv_pct = 0;
			end
			if (p == 4)
				pressure_armed = 1'b1;
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_word(random_word(), 1'b0, NO_RESULT);
			drain();
		end

		$display("Sent %0d words (%0d from the table) over %0d limit settings with stall mixes",
			words_sent, N_DIRECTED, N_PHASES + 1);
		$display("Checked %0d result words, %0d with the IRQ line high; long hold-off %0s",
			results_checked, irq_results, pressure_done ? "done" : "missed");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#(200_000 * 20);
		$display("Timed out with %0d results outstanding", results_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_core.sv
rtl/core/cartridge_bank_mapper_irq_counter.sv
sim/cartridge_bank_mapper_irq_counter_test.sv
